// ===== design/asvm_pkg.sv =====
package asvm_pkg;

    // Voice bank geometry.
    localparam int VOICES         = 8;
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;

    // Quarter-wave sine table geometry.
    localparam int QTR_BITS = SINE_ADDR_BITS - 2;
    localparam int QTR_LEN  = 1 << QTR_BITS;

    // Datapath widths. One voice term is sine * level * main gain, below 2^47.
    localparam int VOICE_BITS = $clog2(VOICES);
    localparam int CNT_W      = $clog2(VOICES + 1);
    localparam int PROD_W     = 48;
    localparam int ACC_W      = PROD_W + VOICE_BITS;
    localparam int MR_W       = ACC_W - 15;
    localparam int GM_W       = MR_W + 16;
    localparam int NUM_W      = GM_W - 29;
    localparam int DC_W       = $clog2(NUM_W + 1);

    // Stream payload layout.
    localparam int S_TDATA_W = 56;
    localparam int IDX_LSB   = 0;
    localparam int STEP_LSB  = 3;
    localparam int GAIN_LSB  = 35;
    localparam int EN_LSB    = 51;

    // Item kinds carried on tuser.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Configuration register indexes.
    localparam logic REG_MAIN_GAIN   = 1'b0;
    localparam logic REG_VOICE_COUNT = 1'b1;

    // Reset values.
    localparam logic [15:0] MAIN_GAIN_RST   = 16'd8192;
    localparam logic [3:0]  VOICE_COUNT_RST = 4'd5;
    localparam logic [15:0] LEVEL_RST       = 16'd8192;

    // Polynomial coefficients of the quarter sine, Q30.
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned SC1     = 64'd1686629713;
    localparam longint unsigned SC3     = 64'd693598670;
    localparam longint unsigned SC5     = 64'd85569306;
    localparam longint unsigned SC7     = 64'd5026995;
    localparam longint unsigned SC9     = 64'd172272;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } mix_state_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic go;
        logic active;
        logic wr;
    } cell_ctrl_t;

    // Voice settings carried by a settings beat.
    typedef struct packed {
        logic [PHASE_BITS-1:0] step;
        logic [15:0]           level;
        logic                  on;
    } voice_set_t;

    // Partial sum handed from one cell to the next.
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
    } link_t;

    typedef logic [14:0] sine_qtr_t [QTR_LEN];

    // One quarter-wave entry, evaluated at elaboration.
    function automatic logic [14:0] sine_entry(input int x);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned y;
        longint unsigned v;
        u  = 64'(unsigned'(x)) << (32 - SINE_ADDR_BITS);
        u2 = (u * u) >> 30;
        t  = SC7 - ((u2 * SC9) >> 30);
        t  = SC5 - ((u2 * t) >> 30);
        t  = SC3 - ((u2 * t) >> 30);
        t  = SC1 - ((u2 * t) >> 30);
        y  = (u * t) >> 30;
        v  = (y * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return 15'(v);
    endfunction

    function automatic sine_qtr_t build_sine_qtr();
        sine_qtr_t tab;
        for (int i = 0; i < QTR_LEN; i++) begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam sine_qtr_t   SINE_QTR  = build_sine_qtr();
    localparam logic [14:0] SINE_PEAK = sine_entry(QTR_LEN);

    // Full-wave sine from quarter-wave symmetry.
    function automatic logic signed [15:0] sine_lookup(input logic [SINE_ADDR_BITS-1:0] addr);
        logic [1:0]          quad;
        logic [QTR_BITS-1:0] r;
        logic [QTR_BITS:0]   x;
        logic [14:0]         v;
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        r    = addr[QTR_BITS-1:0];
        x    = quad[0] ? ((QTR_BITS + 1)'(QTR_LEN) - {1'b0, r}) : {1'b0, r};
        v    = x[QTR_BITS] ? SINE_PEAK : SINE_QTR[x[QTR_BITS-1:0]];
        return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

// ===== design/asvm_cell.sv =====
module asvm_cell import asvm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cell_ctrl_t  ctrl,
    input  voice_set_t  set_data,
    input  logic [15:0] main_gain,
    input  link_t       link_i,
    output link_t       link_o
);

    logic [PHASE_BITS-1:0]   phase_reg;
    logic [PHASE_BITS-1:0]   step_reg;
    logic [15:0]             level_reg;
    logic                    on_reg;
    logic                    en_reg;
    logic signed [15:0]      sine_reg;
    logic signed [32:0]      sl_reg;
    logic signed [32:0]      sl_next;
    logic signed [49:0]      prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    link_t                   link_reg;

    // Voice settings and oscillator phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            step_reg  <= '0;
            level_reg <= LEVEL_RST;
            on_reg    <= 1'b1;
        end else begin
            if (ctrl.wr) begin
                step_reg  <= set_data.step;
                level_reg <= set_data.level;
                on_reg    <= set_data.on;
            end
            if (ctrl.go && ctrl.active && on_reg) begin
                phase_reg <= phase_reg + step_reg;
            end
        end
    end

    // Sample the sine of the current phase when a tick starts.
    always_ff @(posedge aclk) begin
        if (ctrl.go) begin
            sine_reg <= sine_lookup(phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS]);
            en_reg   <= ctrl.active && on_reg;
        end
    end

    // Two registered multiplies: by the voice level, then by the main gain.
    always_comb begin
        sl_next   = sine_reg * $signed({1'b0, level_reg});
        prod_full = sl_reg * $signed({1'b0, main_gain});
        prod_next = en_reg ? prod_full[PROD_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        sl_reg   <= sl_next;
        prod_reg <= prod_next;
    end

    // Add this voice's term to the partial sum passing through.
    always_ff @(posedge aclk) begin
        link_reg.acc <= link_i.acc + ACC_W'(prod_reg);
        if (!aresetn) begin
            link_reg.valid <= 1'b0;
        end else begin
            link_reg.valid <= link_i.valid;
        end
    end

    assign link_o = link_reg;

endmodule

// ===== design/asvm_tail.sv =====
module asvm_tail import asvm_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] acc_i,
    input  logic [15:0]             main_gain,
    input  logic [CNT_W-1:0]        cnt,
    output logic                    done,
    output logic [15:0]             sample
);

    logic                v1_reg;
    logic                v2_reg;
    logic                busy_reg;
    logic                fin_reg;
    logic [DC_W-1:0]     div_cnt_reg;
    logic                neg_reg;
    logic [MR_W-1:0]     magr_reg;
    logic [MR_W-1:0]     magr_next;
    logic [GM_W-1:0]     gm_reg;
    logic [GM_W-1:0]     gm_next;
    logic [ACC_W-1:0]    mag;
    logic [ACC_W-1:0]    mag_rnd;
    logic [GM_W:0]       nsum;
    logic [NUM_W-1:0]    num;
    logic [NUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W:0]      rem_sh;
    logic                qbit;
    logic [CNT_W-1:0]    rem_next;

    // Magnitude rounded to 2^-30 units, then weighed by the main gain again.
    always_comb begin
        mag       = acc_i[ACC_W-1] ? unsigned'(-acc_i) : unsigned'(acc_i);
        mag_rnd   = mag + ACC_W'(1 << 14);
        magr_next = mag_rnd[ACC_W-1:15];
        gm_next   = magr_reg * main_gain;
        nsum      = {1'b0, gm_reg} + ((GM_W + 1)'(cnt) << 29);
        num       = nsum[GM_W:30];
    end

    // One restoring division step per cycle by the voice count.
    always_comb begin
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        qbit   = (rem_sh >= {1'b0, cnt});
        rem_next = qbit ? CNT_W'(rem_sh - {1'b0, cnt}) : rem_sh[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg  <= acc_i[ACC_W-1];
            magr_reg <= magr_next;
        end
        if (v1_reg) begin
            gm_reg <= gm_next;
        end
        if (v2_reg) begin
            quo_reg <= num;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    // Stage sequencing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            busy_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            div_cnt_reg <= '0;
        end else begin
            v1_reg  <= start;
            v2_reg  <= v1_reg;
            fin_reg <= 1'b0;
            if (v2_reg) begin
                busy_reg    <= 1'b1;
                div_cnt_reg <= DC_W'(NUM_W);
            end else if (busy_reg) begin
                div_cnt_reg <= div_cnt_reg - DC_W'(1);
                if (div_cnt_reg == DC_W'(1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // Sign and saturate; the quotient holds until the next start.
    always_comb begin
        if (neg_reg) begin
            sample = (quo_reg > NUM_W'(32768)) ? 16'h8000 : 16'(-quo_reg[15:0]);
        end else begin
            sample = (quo_reg > NUM_W'(32767)) ? 16'h7FFF : quo_reg[15:0];
        end
    end

    assign done = fin_reg;

endmodule

// ===== design/additive_sine_voice_mixer_core.sv =====
// Additive sine voice mixer: a row of oscillator cells, one per voice, summed
// into one signed Q1.15 sample per tick beat (s_tuser = 0). A settings beat
// (s_tuser = 1) writes one voice's step, level and enable and yields no
// output. A tick passes a table lookup and two multiplies registered in
// every cell at once, one register per cell as the partial sum walks the
// chain, three rounding and gain stages, a bit-serial divide by the voice
// count that takes one quotient bit per cycle (23 bits), and a hold state
// that waits for the output register to be free before loading it.
// s_tready is low until then; a finished sample waits in the output
// register while the next beat is taken. main_gain and voice_count are to
// be written through the cfg port only while the block is idle; the block
// does not enforce this.
module additive_sine_voice_mixer_core import asvm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] voice_index, [34:3] phase_step, [50:35] voice_gain,
    // [51] voice_enable, [55:52] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] sample
    output logic [15:0]          m_tdata
);

    mix_state_t         state_reg;
    mix_state_t         state_next;
    logic [15:0]        main_gain_reg;
    logic [3:0]         voice_count_reg;
    logic [CNT_W-1:0]   cnt_eff;
    logic [2:0]         go_pipe_reg;
    logic               in_beat;
    logic               tick_go;
    logic               set_wr;
    logic               load_out;
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;
    logic [2:0]         voice_index;
    voice_set_t         set_data;
    link_t              chain [VOICES+1];
    cell_ctrl_t         ctrl  [VOICES];
    logic               tail_done;
    logic [15:0]        tail_sample;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_gain_reg   <= MAIN_GAIN_RST;
            voice_count_reg <= VOICE_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAIN_GAIN:   main_gain_reg   <= cfg_wdata;
                REG_VOICE_COUNT: voice_count_reg <= cfg_wdata[3:0];
            endcase
        end
    end

    // Voice count clamped to 1..VOICES.
    always_comb begin
        if (voice_count_reg == 4'd0) begin
            cnt_eff = CNT_W'(1);
        end else if (32'(voice_count_reg) > VOICES) begin
            cnt_eff = CNT_W'(VOICES);
        end else begin
            cnt_eff = CNT_W'(voice_count_reg);
        end
    end

    // Input beat decode.
    assign in_beat       = s_tvalid && s_tready;
    assign tick_go       = in_beat && (s_tuser[0] == OP_TICK);
    assign set_wr        = in_beat && (s_tuser[0] == OP_SET);
    assign voice_index   = s_tdata[IDX_LSB +: 3];
    assign set_data.step  = s_tdata[STEP_LSB +: PHASE_BITS];
    assign set_data.level = s_tdata[GAIN_LSB +: 16];
    assign set_data.on    = s_tdata[EN_LSB];

    // The chain starts once every cell has its weighted term ready.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            go_pipe_reg <= '0;
        end else begin
            go_pipe_reg <= {go_pipe_reg[1:0], tick_go};
        end
    end

    assign chain[0].valid = go_pipe_reg[2];
    assign chain[0].acc   = '0;

    // Row of voice cells.
    for (genvar i = 0; i < VOICES; i++) begin : g_cell
        assign ctrl[i].go     = tick_go;
        assign ctrl[i].active = (32'(cnt_eff) > i);
        assign ctrl[i].wr     = set_wr && (32'(voice_index) == i);

        asvm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl[i]),
            .set_data  (set_data),
            .main_gain (main_gain_reg),
            .link_i    (chain[i]),
            .link_o    (chain[i+1])
        );
    end

    // Rounding, final gain, divide by count and saturation.
    asvm_tail u_tail (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (chain[VOICES].valid),
        .acc_i     (chain[VOICES].acc),
        .main_gain (main_gain_reg),
        .cnt       (cnt_eff),
        .done      (tail_done),
        .sample    (tail_sample)
    );

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (tick_go) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (tail_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= tail_sample;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/asvm_checker.sv =====
module asvm_checker import asvm_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled output beat keeps its sample.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // A tick beat makes the block busy in the next cycle.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_TICK) |=> !s_tready)
        else $error("block still ready after a tick beat");

    // A settings beat completes at once.
    a_set_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == OP_SET) |=> s_tready)
        else $error("block not ready after a settings beat");

    // A new sample appears only at the end of a tick.
    a_out_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("sample produced outside a tick");

endmodule

bind additive_sine_voice_mixer_core asvm_checker u_asvm_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    import asvm_pkg::*;

    // Quarter-sine polynomial coefficients in Q30.
    localparam longint unsigned K_ONE = 64'd1073741824;
    localparam longint unsigned K1    = 64'd1686629713;
    localparam longint unsigned K3    = 64'd693598670;
    localparam longint unsigned K5    = 64'd85569306;
    localparam longint unsigned K7    = 64'd5026995;
    localparam longint unsigned K9    = 64'd172272;

    localparam int WAVE_LEN    = 1 << SINE_ADDR_BITS;
    localparam int SETTLE_CYC  = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;

    // One stimulus beat; hold makes the sender wait until all samples are back.
    typedef struct {
        logic        op;
        logic [2:0]  idx;
        logic [31:0] step;
        logic [15:0] gain;
        logic        en;
        bit          hold;
    } beat_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [0:0]           cfg_index = '0;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;

    additive_sine_voice_mixer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Mixer state as the testbench predicts it.
    int          wave_tab [WAVE_LEN];
    logic [31:0] osc_phase [VOICES];
    logic [31:0] osc_step [VOICES];
    logic [15:0] osc_level [VOICES];
    logic        osc_on [VOICES];
    logic [15:0] mix_gain  = MAIN_GAIN_RST;
    logic [3:0]  mix_count = VOICE_COUNT_RST;

    beat_t       beat_q [$];
    logic [15:0] sample_q [$];
    int          n_queued   = 0;
    int          n_accepted = 0;
    int          n_samples  = 0;
    int          errors     = 0;
    bit          tx_idle    = 1'b1;
    bit          rx_idle    = 1'b1;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // One entry of the quarter wave at position x of QTR_LEN.
    function automatic int quarter_sine(input int x);
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t;
        longint unsigned y;
        longint unsigned v;
        u  = longint'(x) << (32 - SINE_ADDR_BITS);
        u2 = (u * u) >> 30;
        t  = K7 - ((u2 * K9) >> 30);
        t  = K5 - ((u2 * t) >> 30);
        t  = K3 - ((u2 * t) >> 30);
        t  = K1 - ((u2 * t) >> 30);
        y  = (u * t) >> 30;
        v  = (y * 64'd32767 + (K_ONE >> 1)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return int'(v);
    endfunction

    // Sum all sounding voices for one tick and advance their phases.
    function automatic logic [15:0] mix_tick();
        longint          acc;
        longint unsigned mag;
        longint unsigned div;
        longint unsigned q;
        int              cnt;
        int              s;
        bit              neg;
        cnt = (mix_count == 0) ? 1 : (mix_count > VOICES) ? VOICES : int'(mix_count);
        acc = 0;
        for (int v = 0; v < cnt; v++) begin
            if (osc_on[v]) begin
                acc += longint'(wave_tab[osc_phase[v][31 -: SINE_ADDR_BITS]])
                       * longint'(osc_level[v]) * longint'(mix_gain);
                osc_phase[v] = osc_phase[v] + osc_step[v];
            end
        end
        neg = (acc < 0);
        mag = neg ? longint'(-acc) : longint'(acc);
        mag = (mag + 64'd16384) >> 15;
        mag = mag * longint'(mix_gain);
        div = longint'(cnt) << 30;
        q   = (mag + (div >> 1)) / div;
        if (neg) begin
            s = (q > 64'd32768) ? -32768 : -int'(q);
        end else begin
            s = (q > 64'd32767) ? 32767 : int'(q);
        end
        return s[15:0];
    endfunction

    task automatic add_tick();
        beat_t b;
        b.op   = OP_TICK;
        b.idx  = 3'($urandom);
        b.step = $urandom;
        b.gain = 16'($urandom);
        b.en   = 1'($urandom);
        b.hold = 1'b0;
        beat_q.push_back(b);
        n_queued++;
    endtask

    task automatic add_voice(input int idx, input logic [31:0] step, input int gain,
                             input bit en, input bit hold);
        beat_t b;
        b.op   = OP_SET;
        b.idx  = 3'(idx);
        b.step = step;
        b.gain = 16'(gain);
        b.en   = en;
        b.hold = hold;
        beat_q.push_back(b);
        n_queued++;
    endtask

    // Block until every beat is taken and every sample is back, then let it settle.
    task automatic wait_drained();
        while (n_accepted != n_queued || sample_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Write both registers on consecutive edges and mirror them in the predictor.
    task automatic write_mix_config(input int gain, input int count);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAIN_GAIN;
        cfg_wdata <= 16'(gain);
        @(posedge aclk);
        cfg_index <= REG_VOICE_COUNT;
        cfg_wdata <= 16'(count & 15);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mix_gain  = 16'(gain);
        mix_count = 4'(count);
    endtask

    // Mostly ticks with random voice rewrites in between; the hold point is
    // always a settings beat.
    task automatic add_random_run(input int n, input int hold_at);
        int          r;
        logic [31:0] step;
        int          gain;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at || $urandom_range(0, 99) < 28) begin
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    step = $urandom_range(0, 32'h0400_0000);
                end else if (r < 8) begin
                    step = $urandom;
                end else if (r == 8) begin
                    step = '0;
                end else begin
                    step = '1;
                end
                r = $urandom_range(0, 9);
                gain = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535);
                add_voice($urandom_range(0, 7), step, gain, $urandom_range(0, 5) != 0,
                          i == hold_at);
            end else begin
                add_tick();
            end
        end
    endtask

    // Stimulus sequencing: directed checks, then random phases with fresh settings.
    initial begin : stim_proc
        int gain;
        int r;
        for (int a = 0; a < WAVE_LEN; a++) begin
            r = quarter_sine((a[SINE_ADDR_BITS-2] == 1'b1) ?
                             (QTR_LEN - (a % QTR_LEN)) : (a % QTR_LEN));
            wave_tab[a] = a[SINE_ADDR_BITS-1] ? -r : r;
        end
        for (int v = 0; v < VOICES; v++) begin
            osc_phase[v] = '0;
            osc_step[v]  = '0;
            osc_level[v] = LEVEL_RST;
            osc_on[v]    = 1'b1;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Silent reset state, then one voice per kind of setting.
        add_tick();
        add_voice(0, 32'h4000_0000, 65535, 1'b1, 1'b0);
        add_voice(1, 32'hFFFF_FFFF, 0, 1'b1, 1'b0);
        add_voice(2, 32'h8000_0000, 32768, 1'b0, 1'b0);
        add_voice(3, 32'h1234_5678, 65535, 1'b1, 1'b0);
        add_voice(4, 32'h0040_0000, 1, 1'b1, 1'b0);
        add_voice(7, 32'h2000_0000, 65535, 1'b1, 1'b0);
        repeat (4) add_tick();
        wait_drained();

        // Full gain on one voice drives both saturation limits.
        write_mix_config(65535, 1);
        repeat (4) add_tick();
        wait_drained();

        // Zero gain, and a voice count of zero acting as one.
        write_mix_config(0, 0);
        repeat (2) add_tick();
        wait_drained();

        // A count above the bank size acts as all voices.
        write_mix_config(32768, 15);
        add_voice(5, 32'hA5A5_5A5A, 40000, 1'b1, 1'b0);
        add_voice(6, 32'h5A5A_A5A5, 25000, 1'b1, 1'b0);
        repeat (3) add_tick();
        wait_drained();

        // Random phases, each under its own register setting.
        for (int p = 0; p < 5; p++) begin
            r = $urandom_range(0, 3);
            gain = (r == 0) ? 65535 : (r == 1) ? 32768 : $urandom_range(0, 65535);
            write_mix_config((p == 0) ? 32768 : gain, (p == 0) ? 8 : $urandom_range(0, 15));
            tx_idle = (p != 3);
            rx_idle = (p != 2);
            add_random_run(160, (p == 1) ? 80 : -1);
            wait_drained();
        end

        // Last stretch at reset settings with both sides running flat out.
        write_mix_config(MAIN_GAIN_RST, VOICE_COUNT_RST);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        add_random_run(150, -1);
        wait_drained();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Sender: predict each accepted beat, then offer the next one from the queue.
    always @(posedge aclk) begin : send_proc
        beat_t nxt;
        int    gap_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                n_accepted++;
                if (s_tuser == OP_SET) begin
                    osc_step[s_tdata[2:0]]  = s_tdata[34:3];
                    osc_level[s_tdata[2:0]] = s_tdata[50:35];
                    osc_on[s_tdata[2:0]]    = s_tdata[51];
                end else begin
                    sample_q.push_back(mix_tick());
                end
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (beat_q.size() != 0 &&
                             !(beat_q[0].hold && sample_q.size() != 0)) begin
                    nxt = beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.op;
                    s_tdata  <= {4'b0, nxt.en, nxt.gain, nxt.step, nxt.idx};
                    if (tx_idle && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 5);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each sample beat and apply back-pressure.
    always @(posedge aclk) begin : recv_proc
        logic [15:0] want;
        int          stall_left;
        int          long_left;
        bit          long_done;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            long_left  = 0;
            long_done  = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_samples++;
                if (sample_q.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, got %0d",
                             $time, $signed(m_tdata));
                    errors++;
                end else begin
                    want = sample_q.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: sample mismatch, expected %0d, got %0d",
                                 $time, $signed(want), $signed(m_tdata));
                        errors++;
                    end
                end
            end
            // One long hold lets the output fill up and stall the input.
            if (long_left > 0) begin
                long_left--;
                m_tready <= 1'b0;
            end else if (!long_done && n_samples >= 60) begin
                long_done = 1'b1;
                long_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle && $urandom_range(0, 4) == 0) begin
                    stall_left = $urandom_range(1, 5);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin : watchdog_proc
        int cycles;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
design/asvm_pkg.sv
design/asvm_cell.sv
design/asvm_tail.sv
design/additive_sine_voice_mixer_core.sv
design/asvm_checker.sv
tb/tb_top.sv
